// ----- rtl/watch_table_add_modify_delete_top_assert.svh -----
// Assertion macros shared by the watch table checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef WATCH_TABLE_ADD_MODIFY_DELETE_TOP_ASSERT_SVH
`define WATCH_TABLE_ADD_MODIFY_DELETE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WTBL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watch table assertion failed");

// next-cycle implication, checked outside reset
`define WTBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("watch table assertion failed");

`endif

// ----- rtl/wtbl_pkg.sv -----
// Shared types and constants of the watch table.
// No dependencies.
package wtbl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int FD_W     = 16;
  localparam int MASK_W   = 32;
  localparam int TAG_W    = 64;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MODIFY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [FD_W-1:0]   fd;
    logic [MASK_W-1:0] events;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic check;
    logic scan;
    logic act;
    logic move;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad_req;
    logic scan_done;
    logic need_move;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/wtbl_ctrl.sv -----
// Request sequencer of the watch table: check, scan, update, move, respond.
// Depends on wtbl_pkg.
module wtbl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wtbl_pkg::sts_t sts,
  output wtbl_pkg::cmd_t cmd
);
  import wtbl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_ACT    = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = !rst_n || (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.bad_req ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_ACT;
      end
      S_ACT: begin
        cmd.act = 1'b1;
        state_nxt = sts.need_move ? S_MOVE : S_FINISH;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/wtbl_dp.sv -----
// Datapath of the watch table: request registers, entry memory, scan
// pointer, entry count and the result register. Depends on wtbl_pkg.
module wtbl_dp #(
  parameter int TABLE_ENTRIES = wtbl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wtbl_pkg::cmd_t                cmd,
  output wtbl_pkg::sts_t                sts,
  input  logic [wtbl_pkg::ACTION_W-1:0] in_action,
  input  logic [wtbl_pkg::FD_W-1:0]     in_key_fd,
  input  logic                          in_has_event,
  input  logic [wtbl_pkg::MASK_W-1:0]   in_event_mask,
  input  logic [wtbl_pkg::TAG_W-1:0]    in_user_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wtbl_pkg::STATUS_W-1:0] out_status,
  output logic [wtbl_pkg::COUNT_W-1:0]  out_entry_count
);
  import wtbl_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  logic [ACTION_W-1:0] action_r, action_nxt;
  logic [FD_W-1:0]     key_r, key_nxt;
  logic                has_ev_r, has_ev_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;

  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       scan_idx_r, scan_idx_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]       pend_idx_r, pend_idx_nxt;
  logic                found_r, found_nxt;
  logic [IW-1:0]       hit_r, hit_nxt;
  logic [STATUS_W-1:0] result_r, result_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  entry_t              slot_mem [TABLE_ENTRIES];
  entry_t              rd_data_r;
  logic                rd_en, wr_en;
  logic [IW-1:0]       rd_addr, wr_addr;
  entry_t              wr_data;

  logic [CW-1:0]       last_idx;
  logic                match_now;
  logic                more;

  assign last_idx  = count_r - CW'(1);
  assign match_now = rd_pend_r && (rd_data_r.fd == key_r);
  assign more      = scan_idx_r < count_r;

  assign sts.bad_req   = (action_r == ACT_UNKNOWN) || ((action_r != ACT_DELETE) && !has_ev_r);
  assign sts.scan_done = match_now || (!rd_pend_r && !more);
  assign sts.need_move = (action_r == ACT_DELETE) && found_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  always_comb begin
    action_nxt     = action_r;
    key_nxt        = key_r;
    has_ev_nxt     = has_ev_r;
    mask_nxt       = mask_r;
    tag_nxt        = tag_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = rd_pend_r;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    result_nxt     = result_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    rd_en   = 1'b0;
    rd_addr = scan_idx_r[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = hit_r;
    wr_data = rd_data_r;

    if (cmd.accept) begin
      action_nxt = in_action;
      key_nxt    = in_key_fd;
      has_ev_nxt = in_has_event;
      mask_nxt   = in_event_mask;
      tag_nxt    = in_user_tag;
    end

    if (cmd.check) begin
      result_nxt   = ST_INVALID;
      scan_idx_nxt = '0;
      rd_pend_nxt  = 1'b0;
      found_nxt    = 1'b0;
    end

    // one read issued per cycle, its data compared against the key in the next cycle
    if (cmd.scan) begin
      rd_pend_nxt = 1'b0;
      if (match_now) begin
        found_nxt = 1'b1;
        hit_nxt   = pend_idx_r;
      end else if (more) begin
        rd_en        = 1'b1;
        rd_addr      = scan_idx_r[IW-1:0];
        pend_idx_nxt = scan_idx_r[IW-1:0];
        scan_idx_nxt = scan_idx_r + CW'(1);
        rd_pend_nxt  = 1'b1;
      end
    end

    if (cmd.act) begin
      unique case (action_r)
        ACT_ADD: begin
          if (found_r) begin
            result_nxt = ST_EXISTS;
          end else if (count_r == FULL_COUNT) begin
            result_nxt = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = count_r[IW-1:0];
            wr_data    = '{fd: key_r, events: mask_r, tag: tag_r};
            count_nxt  = count_r + CW'(1);
            result_nxt = ST_OK;
          end
        end
        ACT_MODIFY: begin
          if (!found_r) begin
            result_nxt = ST_NOTFOUND;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = hit_r;
            wr_data    = '{fd: key_r, events: mask_r, tag: tag_r};
            result_nxt = ST_OK;
          end
        end
        ACT_DELETE: begin
          if (!found_r) begin
            result_nxt = ST_NOTFOUND;
          end else begin
            // fetch the last live entry; it lands in the freed slot next cycle
            rd_en      = 1'b1;
            rd_addr    = last_idx[IW-1:0];
            result_nxt = ST_OK;
          end
        end
        default: result_nxt = ST_INVALID;
      endcase
    end

    if (cmd.move) begin
      wr_en     = 1'b1;
      wr_addr   = hit_r;
      wr_data   = rd_data_r;
      count_nxt = count_r - CW'(1);
    end

    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = result_r;
      out_count_nxt  = COUNT_W'(count_r);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    has_ev_r     <= has_ev_nxt;
    mask_r       <= mask_nxt;
    tag_r        <= tag_nxt;
    scan_idx_r   <= scan_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    hit_r        <= hit_nxt;
    result_r     <= result_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= slot_mem[rd_addr];
  end

endmodule

// ----- rtl/watch_table_add_modify_delete_top.sv -----
// Watch table top level: sequencer plus datapath.
// Depends on wtbl_pkg, wtbl_ctrl and wtbl_dp.
//
// Keeps up to TABLE_ENTRIES watched descriptors (descriptor, event mask,
// 64-bit tag) and serves one add, modify or delete request at a time, each
// answered by one transaction carrying a status and the entry count after
// the request (count taken modulo 128). A request is searched for by a
// linear scan of the live entries through the single read port of the
// entry memory, one entry read per cycle, each compared against the key
// once its read data is registered. A match ends the scan early; a delete
// that finds its entry then moves the last entry into the freed slot. An
// invalid request skips the scan and the update. The memory needs no
// clearing after reset: only entries below the count are ever read. Input
// stall stays high while a request is in work, and the result register
// lets the next request be accepted while a result waits.
module watch_table_add_modify_delete_top #(
  parameter int TABLE_ENTRIES = wtbl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wtbl_pkg::ACTION_W-1:0] in_action,
  input  logic [wtbl_pkg::FD_W-1:0]     in_key_fd,
  input  logic                          in_has_event,
  input  logic [wtbl_pkg::MASK_W-1:0]   in_event_mask,
  input  logic [wtbl_pkg::TAG_W-1:0]    in_user_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wtbl_pkg::STATUS_W-1:0] out_status,
  output logic [wtbl_pkg::COUNT_W-1:0]  out_entry_count
);
  import wtbl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wtbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wtbl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_key_fd       (in_key_fd),
    .in_has_event    (in_has_event),
    .in_event_mask   (in_event_mask),
    .in_user_tag     (in_user_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

// ----- rtl/wtbl_checker.sv -----
// Port-level checks of the watch table, bound to the top level.
// Depends on wtbl_pkg and watch_table_add_modify_delete_top_assert.svh.
`include "watch_table_add_modify_delete_top_assert.svh"

module wtbl_checker #(
  parameter int TABLE_ENTRIES = wtbl_pkg::TABLE_ENTRIES_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [wtbl_pkg::STATUS_W-1:0] out_status,
  input logic [wtbl_pkg::COUNT_W-1:0]  out_entry_count
);
  import wtbl_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(TABLE_ENTRIES);

  // a held result transaction keeps its payload
  `WTBL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))
  `WTBL_ASSERT_NEXT(a_count_hold, out_valid && out_stall, $stable(out_entry_count))

  // one request in work at a time
  `WTBL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a full report always comes with a full table
  `WTBL_ASSERT_NOW(a_full_count, out_valid && (out_status == ST_FULL), out_entry_count == FULL_CNT)

  // only defined status codes leave the block
  `WTBL_ASSERT_NOW(a_status_code, out_valid, out_status <= ST_NOTFOUND)

endmodule

bind watch_table_add_modify_delete_top wtbl_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_wtbl_checker (.*);
